@@ rtl/core/cdad_pkg.sv @@
`default_nettype none
package cdad_pkg;

   localparam int unsigned DATE_W = 27;
   localparam int unsigned DAYS_W = 12;
   localparam int unsigned STATUS_W = 2;

   localparam logic [DATE_W-1:0] DAY_SCALE = 27'd1000000;
   localparam logic [DATE_W-1:0] MON_SCALE = 27'd10000;
   localparam logic [DATE_W-1:0] CEN_SCALE = 27'd100;
   localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;
   localparam logic [6:0] MAX_TWO_DIGIT = 7'd99;

   // reciprocals 2^k / scale rounded up, exact for each step's dividends
   localparam int unsigned RECIP_W = 28;
   localparam logic [RECIP_W-1:0] DAY_RECIP = 28'd140737489;
   localparam int unsigned DAY_SHIFT = 47;
   localparam logic [RECIP_W-1:0] MON_RECIP = 28'd1717987;
   localparam int unsigned MON_SHIFT = 34;
   localparam logic [RECIP_W-1:0] CEN_RECIP = 28'd20972;
   localparam int unsigned CEN_SHIFT = 21;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_INVALID  = 2'd1,
      ST_OVERFLOW = 2'd2
   } cdad_status_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_DAY,
      F_MON,
      F_CEN,
      F_PUSH
   } cdad_front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_RUN,
      B_PACK
   } cdad_back_state_type;

   // one classified word between front and back
   typedef struct packed {
      logic [DATE_W-1:0] packed_date;
      logic [7:0]        day;
      logic [6:0]        month;
      logic [6:0]        century;
      logic [6:0]        low_year;
      logic [DAYS_W-1:0] add;
      logic              invalid;
   } cdad_item_type;

   // year % 4 equals low % 4 since 100 is a multiple of 4
   function automatic logic is_leap(input logic [6:0] century, input logic [6:0] low_year);
      logic leap;
      if (low_year == 7'd0) leap = (century[1:0] == 2'd0);
      else                  leap = (low_year[1:0] == 2'd0);
      return leap;
   endfunction

   function automatic logic [4:0] month_len(input logic [6:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
         7'd4, 7'd6, 7'd9, 7'd11:                    len = 5'd30;
         7'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/cdad_req_if.sv @@
`default_nettype none
interface cdad_req_if;
   logic                           valid;
   logic                           ready;
   logic [cdad_pkg::DATE_W-1:0]    start_date;
   logic [cdad_pkg::DAYS_W-1:0]    days_to_add;

   modport source (output valid, output start_date, output days_to_add, input ready);
   modport sink   (input valid, input start_date, input days_to_add, output ready);
endinterface
`default_nettype wire

@@ rtl/core/cdad_rsp_if.sv @@
`default_nettype none
interface cdad_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [cdad_pkg::DATE_W-1:0]    result_date;
   logic [cdad_pkg::STATUS_W-1:0]  status;

   modport source (output valid, output result_date, output status, input ready);
   modport sink   (input valid, input result_date, input status, output ready);
endinterface
`default_nettype wire

@@ rtl/core/cdad_front.sv @@
`default_nettype none
module cdad_front (
   input  wire logic            clock,
   input  wire logic            reset,
   cdad_req_if.sink             req_ch,
   output cdad_pkg::cdad_item_type push_item,
   output logic                 push_valid,
   input  wire logic            queue_full
);

   cdad_pkg::cdad_front_state_type state_ff, state_in;
   logic [cdad_pkg::DATE_W-1:0] packed_ff, packed_in;
   logic [cdad_pkg::DATE_W-1:0] rem_ff, rem_in;
   logic [cdad_pkg::DAYS_W-1:0] add_ff, add_in;
   logic [7:0] quo_ff, quo_in;
   logic       rem_phase_ff, rem_phase_in;
   logic [7:0] day_ff, day_in;
   logic [6:0] mon_ff, mon_in;
   logic [6:0] cen_ff, cen_in;

   logic [cdad_pkg::DATE_W-1:0]                  base;
   logic [cdad_pkg::RECIP_W-1:0]                 recip;
   logic [cdad_pkg::DATE_W+cdad_pkg::RECIP_W-1:0] prod;
   logic [7:0]                                   quo_est;
   logic [cdad_pkg::DATE_W-1:0]                  back_off;
   logic [4:0]                                   len;

   // quotient by reciprocal multiply, remainder on the next cycle
   always_comb begin
      case (state_ff)
         cdad_pkg::F_DAY: begin
            base  = cdad_pkg::DAY_SCALE;
            recip = cdad_pkg::DAY_RECIP;
         end
         cdad_pkg::F_MON: begin
            base  = cdad_pkg::MON_SCALE;
            recip = cdad_pkg::MON_RECIP;
         end
         default: begin
            base  = cdad_pkg::CEN_SCALE;
            recip = cdad_pkg::CEN_RECIP;
         end
      endcase
      prod = (cdad_pkg::DATE_W+cdad_pkg::RECIP_W)'(rem_ff)
           * (cdad_pkg::DATE_W+cdad_pkg::RECIP_W)'(recip);
      case (state_ff)
         cdad_pkg::F_DAY: quo_est = prod[cdad_pkg::DAY_SHIFT +: 8];
         cdad_pkg::F_MON: quo_est = prod[cdad_pkg::MON_SHIFT +: 8];
         default:         quo_est = prod[cdad_pkg::CEN_SHIFT +: 8];
      endcase
      back_off = {{(cdad_pkg::DATE_W-8){1'b0}}, quo_ff} * base;
   end

   assign len = cdad_pkg::month_len(mon_ff, cdad_pkg::is_leap(cen_ff, rem_ff[6:0]));

   always_comb begin
      push_item.packed_date = packed_ff;
      push_item.day         = day_ff;
      push_item.month       = mon_ff;
      push_item.century     = cen_ff;
      push_item.low_year    = rem_ff[6:0];
      push_item.add         = add_ff;
      push_item.invalid     = (len == 5'd0) || (day_ff == 8'd0) || (day_ff > {3'd0, len});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cdad_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      packed_ff    <= packed_in;
      rem_ff       <= rem_in;
      add_ff       <= add_in;
      quo_ff       <= quo_in;
      rem_phase_ff <= rem_phase_in;
      day_ff       <= day_in;
      mon_ff       <= mon_in;
      cen_ff       <= cen_in;
   end

   always_comb begin
      state_in     = state_ff;
      packed_in    = packed_ff;
      rem_in       = rem_ff;
      add_in       = add_ff;
      quo_in       = quo_ff;
      rem_phase_in = rem_phase_ff;
      day_in       = day_ff;
      mon_in       = mon_ff;
      cen_in       = cen_ff;
      req_ch.ready = 1'b0;
      push_valid   = 1'b0;
      case (state_ff)
         cdad_pkg::F_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               packed_in    = req_ch.start_date;
               rem_in       = req_ch.start_date;
               add_in       = req_ch.days_to_add;
               rem_phase_in = 1'b0;
               state_in     = cdad_pkg::F_DAY;
            end
         end
         cdad_pkg::F_DAY, cdad_pkg::F_MON, cdad_pkg::F_CEN: begin
            if (!rem_phase_ff) begin
               quo_in       = quo_est;
               rem_phase_in = 1'b1;
            end else begin
               rem_in       = rem_ff - back_off;
               rem_phase_in = 1'b0;
               case (state_ff)
                  cdad_pkg::F_DAY: begin
                     day_in   = quo_ff;
                     state_in = cdad_pkg::F_MON;
                  end
                  cdad_pkg::F_MON: begin
                     mon_in   = quo_ff[6:0];
                     state_in = cdad_pkg::F_CEN;
                  end
                  default: begin
                     cen_in   = quo_ff[6:0];
                     state_in = cdad_pkg::F_PUSH;
                  end
               endcase
            end
         end
         cdad_pkg::F_PUSH: begin
            push_valid = 1'b1;
            if (!queue_full) state_in = cdad_pkg::F_IDLE;
         end
         default: state_in = cdad_pkg::F_IDLE;
      endcase
   end

endmodule
`default_nettype wire

@@ rtl/core/cdad_queue.sv @@
`default_nettype none
module cdad_queue #(
   parameter int unsigned Depth = 2
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push_valid,
   input  wire cdad_pkg::cdad_item_type push_item,
   output logic                         full,
   output logic                         pop_valid,
   output cdad_pkg::cdad_item_type      pop_item,
   input  wire logic                    pop
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   cdad_pkg::cdad_item_type entries_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full      = (count_ff == FullCnt);
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entries_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) entries_ff[wr_ptr_ff] <= push_item;
   end

endmodule
`default_nettype wire

@@ rtl/core/cdad_back.sv @@
`default_nettype none
module cdad_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    pop_valid,
   input  wire cdad_pkg::cdad_item_type pop_item,
   output logic                         pop,
   cdad_rsp_if.source                   rsp_ch
);

   cdad_pkg::cdad_back_state_type state_ff, state_in;
   cdad_pkg::cdad_status_type     status_ff, status_in;
   logic [cdad_pkg::DATE_W-1:0] packed_ff, packed_in;
   logic [12:0] nd_ff, nd_in;
   logic [3:0]  month_ff, month_in;
   logic [6:0]  cen_ff, cen_in;
   logic [6:0]  low_ff, low_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [cdad_pkg::DATE_W-1:0]   rsp_date_ff, rsp_date_in;
   cdad_pkg::cdad_status_type     rsp_status_ff, rsp_status_in;

   logic [4:0]                  len;
   logic [cdad_pkg::DATE_W-1:0] repacked;
   logic                        out_free;

   assign len = cdad_pkg::month_len({3'd0, month_ff}, cdad_pkg::is_leap(cen_ff, low_ff));
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // day is at most 31 here
   assign repacked = cdad_pkg::DATE_W'(nd_ff[4:0]) * cdad_pkg::DAY_SCALE
                   + cdad_pkg::DATE_W'(month_ff) * cdad_pkg::MON_SCALE
                   + cdad_pkg::DATE_W'(cen_ff) * cdad_pkg::CEN_SCALE
                   + cdad_pkg::DATE_W'(low_ff);

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_date = rsp_date_ff;
   assign rsp_ch.status      = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cdad_pkg::B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff     <= status_in;
      packed_ff     <= packed_in;
      nd_ff         <= nd_in;
      month_ff      <= month_in;
      cen_ff        <= cen_in;
      low_ff        <= low_in;
      rsp_date_ff   <= rsp_date_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      status_in     = status_ff;
      packed_in     = packed_ff;
      nd_in         = nd_ff;
      month_in      = month_ff;
      cen_in        = cen_ff;
      low_in        = low_ff;
      rsp_date_in   = rsp_date_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      pop           = 1'b0;
      case (state_ff)
         cdad_pkg::B_IDLE: begin
            if (pop_valid) begin
               pop       = 1'b1;
               packed_in = pop_item.packed_date;
               nd_in     = 13'(pop_item.day) + 13'(pop_item.add);
               month_in  = pop_item.month[3:0];
               cen_in    = pop_item.century;
               low_in    = pop_item.low_year;
               if (pop_item.invalid) begin
                  status_in = cdad_pkg::ST_INVALID;
                  state_in  = cdad_pkg::B_PACK;
               end else begin
                  status_in = cdad_pkg::ST_OK;
                  state_in  = cdad_pkg::B_RUN;
               end
            end
         end
         cdad_pkg::B_RUN: begin
            // one month per cycle
            if (nd_ff > 13'(len)) begin
               nd_in = nd_ff - 13'(len);
               if (month_ff == cdad_pkg::MONTHS_PER_YEAR) begin
                  month_in = 4'd1;
                  if (low_ff == cdad_pkg::MAX_TWO_DIGIT) begin
                     low_in = 7'd0;
                     if (cen_ff == cdad_pkg::MAX_TWO_DIGIT) begin
                        status_in = cdad_pkg::ST_OVERFLOW;
                        state_in  = cdad_pkg::B_PACK;
                     end else begin
                        cen_in = cen_ff + 7'd1;
                     end
                  end else begin
                     low_in = low_ff + 7'd1;
                  end
               end else begin
                  month_in = month_ff + 4'd1;
               end
            end else begin
               state_in = cdad_pkg::B_PACK;
            end
         end
         cdad_pkg::B_PACK: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_date_in   = (status_ff == cdad_pkg::ST_OK) ? repacked : packed_ff;
               state_in      = cdad_pkg::B_IDLE;
            end
         end
         default: state_in = cdad_pkg::B_IDLE;
      endcase
   end

endmodule
`default_nettype wire

@@ rtl/core/calendar_date_add_days.sv @@
`default_nettype none
// Adds 0..4095 days to a Gregorian date packed as decimal DDMMYYYY and returns the new date with
// a status (ok, invalid start date, year past 9999); on error the start date comes back as is.
// The front unpacks a word with a reciprocal multiply and a remainder step each for day,
// month and century, checks it in a push state that waits while the queue is full, and
// takes a new word only once the last is pushed; it hands words through a short queue to
// the back, which walks the calendar one month per cycle, crossing up to about 135 month
// boundaries for one item; an invalid date skips the walk. The slower side sets the
// sustained rate: the front for walks of fewer than five months, the month walk beyond that.
// The front works on the next word meanwhile, and a finished result waits in the output
// register without stalling the back's next load.
module calendar_date_add_days #(
   parameter int unsigned QueueDepth = 2
) (
   input wire logic   clock,
   input wire logic   reset,
   cdad_req_if.sink   req_ch,
   cdad_rsp_if.source rsp_ch
);

   cdad_pkg::cdad_item_type push_item, pop_item;
   logic push_valid, queue_full, pop_valid, pop;

   cdad_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_item  (push_item),
      .push_valid (push_valid),
      .queue_full (queue_full)
   );

   cdad_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop        (pop)
   );

   cdad_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop       (pop),
      .rsp_ch    (rsp_ch)
   );

endmodule
`default_nettype wire

@@ rtl/core/cdad_checker.sv @@
`default_nettype none
module cdad_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [cdad_pkg::DATE_W-1:0]     rsp_result_date,
   input wire logic [cdad_pkg::STATUS_W-1:0]   rsp_status
);

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word shown right after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == cdad_pkg::ST_OK) || (rsp_status == cdad_pkg::ST_INVALID)
                    || (rsp_status == cdad_pkg::ST_OVERFLOW))
      else $error("undefined status code");

   a_ok_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == cdad_pkg::ST_OK) |-> (rsp_result_date < 27'd32000000))
      else $error("repacked date out of calendar range");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_result_date) && $stable(rsp_status))
      else $error("stalled result word changed");

endmodule

bind calendar_date_add_days cdad_checker u_cdad_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_result_date (rsp_ch.result_date),
   .rsp_status      (rsp_ch.status)
);
`default_nettype wire
